FILE: src/symmetric_triple_table_assert.svh
// Assertion macros for the symmetric triple table.
`ifndef SYMMETRIC_TRIPLE_TABLE_ASSERT_SVH
`define SYMMETRIC_TRIPLE_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define STT_ASSERT(label, clk, rst_n, prop, msg)
`define STT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: src/stt_pkg.sv
// Shared types and constants of the symmetric triple table.
package stt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int ATOM_BITS_DEF   = 16;

    localparam int MODE_W      = 2;
    localparam int ATOM_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 8;
    localparam int COUNT_OUT_W = 9;

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_DUPLICATE = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

endpackage

FILE: src/stt_if.sv
// Request and response channel interfaces of the symmetric triple table.
interface stt_req_if import stt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ATOM_W-1:0]   atom_first;
    logic [ATOM_W-1:0]   atom_centre;
    logic [ATOM_W-1:0]   atom_last;

    modport source (output valid, mode, atom_first, atom_centre, atom_last, input ready);
    modport sink   (input valid, mode, atom_first, atom_centre, atom_last, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] count_after;

    modport source (output valid, status, slot, count_after, input ready);
    modport sink   (input valid, status, slot, count_after, output ready);
endinterface

FILE: src/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/symmetric_triple_table.sv
// Symmetric triple table: dense table of atom triples with find, add and delete.
//
// i_req carries a mode (find, add, delete) and three atom indices; a word is
// taken when valid and ready are both high. o_rsp returns one word per request:
// status, slot and the entry count after the request.
// A request is scanned against the stored entries one slot per clock through a
// single comparator fed by the table RAM read port. A miss ends the scan after
// the last stored slot, and a hit ends it at the matching slot; a delete that
// moves the last entry into a freed slot then reads that entry from the RAM and
// writes it into the freed slot. i_req.ready rises in the same cycle as the
// result word is registered, and requests are handled one at a time.
// i_req.ready is high only while no request is in progress.
// Reset empties the table (count to zero) and drops any pending result; the
// RAM is not cleared, as only slots below the count are ever read.
// A stalled receiver holds the result word; the next request may still be
// accepted and scanned, and its result waits until the held word is taken.
`include "symmetric_triple_table_assert.svh"

module symmetric_triple_table import stt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ATOM_BITS   = ATOM_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stt_req_if.sink   i_req,
    stt_rsp_if.source o_rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 3 * ATOM_BITS;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_LAST_RD = 5'b00100,
        ST_LAST_WR = 5'b01000,
        ST_EMIT    = 5'b10000
    } t_state;

    t_state                 r_state,  n_state;
    logic [MODE_W-1:0]      r_mode,   n_mode;
    logic [EW-1:0]          r_key,    n_key;
    logic [CW-1:0]          r_ptr,    n_ptr;
    logic [IW-1:0]          r_chk,    n_chk;
    logic                   r_chk_v,  n_chk_v;
    logic [IW-1:0]          r_hit,    n_hit;
    logic [CW-1:0]          r_count,  n_count;
    t_status                r_status, n_status;
    logic [IW-1:0]          r_slot,   n_slot;
    logic                   r_out_valid,  n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [SLOT_W-1:0]      r_out_slot,   n_out_slot;
    logic [COUNT_OUT_W-1:0] r_out_count,  n_out_count;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic [ATOM_BITS-1:0] e_first, e_centre, e_last;
    logic [ATOM_BITS-1:0] k_first, k_centre, k_last;
    logic                 hit_now;
    logic                 ptr_end;
    logic [CW-1:0]        count_last;

    stt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign e_first  = ram_rdata[3*ATOM_BITS-1 -: ATOM_BITS];
    assign e_centre = ram_rdata[2*ATOM_BITS-1 -: ATOM_BITS];
    assign e_last   = ram_rdata[ATOM_BITS-1:0];
    assign k_first  = r_key[3*ATOM_BITS-1 -: ATOM_BITS];
    assign k_centre = r_key[2*ATOM_BITS-1 -: ATOM_BITS];
    assign k_last   = r_key[ATOM_BITS-1:0];

    assign hit_now = r_chk_v && (e_centre == k_centre) &&
                     (((e_first == k_first) && (e_last == k_last)) ||
                      ((e_first == k_last) && (e_last == k_first)));
    assign ptr_end    = (r_ptr == r_count);
    assign count_last = r_count - CW'(1);

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.slot        = r_out_slot;
    assign o_rsp.count_after = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_ptr        = r_ptr;
        n_chk        = r_chk;
        n_chk_v      = r_chk_v;
        n_hit        = r_hit;
        n_count      = r_count;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_count[IW-1:0];
        ram_wdata    = r_key;
        ram_raddr    = r_ptr[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_key   = {ATOM_BITS'(i_req.atom_first), ATOM_BITS'(i_req.atom_centre),
                               ATOM_BITS'(i_req.atom_last)};
                    n_ptr   = '0;
                    n_chk_v = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit_now) begin
                    n_hit    = r_chk;
                    n_chk_v  = 1'b0;
                    n_slot   = r_chk;
                    n_state  = ST_EMIT;
                    unique case (r_mode)
                        MODE_ADD: begin
                            n_status = STATUS_DUPLICATE;
                        end
                        MODE_DELETE: begin
                            n_status = STATUS_OK;
                            if (r_chk == count_last[IW-1:0]) begin
                                n_count = count_last;
                            end else begin
                                n_state = ST_LAST_RD;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end else if (!ptr_end) begin
                    n_chk   = r_ptr[IW-1:0];
                    n_chk_v = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                end else begin
                    n_chk_v = 1'b0;
                    n_slot  = '0;
                    n_state = ST_EMIT;
                    if (r_mode == MODE_ADD) begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_status = STATUS_FULL;
                        end else begin
                            ram_we   = 1'b1;
                            n_status = STATUS_OK;
                            n_slot   = r_count[IW-1:0];
                            n_count  = r_count + CW'(1);
                        end
                    end else begin
                        n_status = STATUS_NOT_FOUND;
                    end
                end
            end
            ST_LAST_RD: begin
                ram_raddr = count_last[IW-1:0];
                n_state   = ST_LAST_WR;
            end
            ST_LAST_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit;
                ram_wdata = ram_rdata;
                n_count   = count_last;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = SLOT_W'(r_slot);
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_ptr        <= n_ptr;
        r_chk        <= n_chk;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

    `STT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH),
                "entry count above table depth")
    `STT_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, i_req.valid && i_req.ready,
                     r_state == ST_SCAN, "accepted word did not start a scan")
    `STT_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1,
                     (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
                     (r_count == $past(r_count) - CW'(1)),
                     "entry count moved by more than one")
    `STT_ASSERT(a_rsp_from_emit, i_clk, i_rst_n,
                $rose(o_rsp.valid) |-> $past(r_state) == ST_EMIT,
                "result raised outside emit")

endmodule
